// ===== sv/sha_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;

	localparam int NumWords = 8;
	localparam int BlockLen = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} comp_ctl_t;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic FuncAbsorb = 1'b0;
	localparam logic FuncFinish = 1'b1;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] r;
		begin
			case (idx)
				3'd0: r = 32'h6a09e667;
				3'd1: r = 32'hbb67ae85;
				3'd2: r = 32'h3c6ef372;
				3'd3: r = 32'ha54ff53a;
				3'd4: r = 32'h510e527f;
				3'd5: r = 32'h9b05688c;
				3'd6: r = 32'h1f83d9ab;
				default: r = 32'h5be0cd19;
			endcase
			return r;
		end
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		begin
			k = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			return k[t];
		end
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== sv/sha_stream_if.sv =====
// Valid/ready stream interface carrying one payload of a chosen type.
`default_nettype none
interface sha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sha_block_buf.sv =====
// Block buffer memory: byte writes, word reads for the message schedule.
`default_nettype none
module sha_block_buf
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [5:0]  wr_addr,
	input  wire logic [7:0]  wr_data,
	input  wire logic [3:0]  rd_addr,
	output logic      [31:0] rd_word
);

	logic [31:0] mem_q [16];

	// Byte-lane write into the addressed word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_addr[1:0])
				2'd0: mem_q[wr_addr[5:2]][31:24] <= wr_data;
				2'd1: mem_q[wr_addr[5:2]][23:16] <= wr_data;
				2'd2: mem_q[wr_addr[5:2]][15:8]  <= wr_data;
				default: mem_q[wr_addr[5:2]][7:0] <= wr_data;
			endcase
		end
	end

	// Registered word read.
	always_ff @(posedge clk) begin
		rd_word <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== sv/sha_round_core.sv =====
// SHA-256 compression: one round per cycle with a rolling 16-word schedule.
`default_nettype none
module sha_round_core
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire comp_ctl_t   ctl,
	input  wire logic [5:0]  round,
	input  wire logic [31:0] msg_word,
	input  wire logic [2:0]  hash_idx,
	input  wire logic        hash_init,
	output logic      [31:0] hash_word
);

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] w_new, w_cur, e, a, t1, t2, s0, s1;
	logic [31:0] v_n [8];
	logic [31:0] h_n [8];

	// Schedule expansion and one round of the working variables.
	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = (round < 6'd16) ? msg_word : w_new;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(round) + w_cur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		v_n[0] = t1 + t2;
		v_n[1] = a;
		v_n[2] = v_q[1];
		v_n[3] = v_q[2];
		v_n[4] = v_q[3] + t1;
		v_n[5] = e;
		v_n[6] = v_q[5];
		v_n[7] = v_q[6];
		for (int i = 0; i < NumWords; i++) begin
			h_n[i] = h_q[i] + v_q[i];
		end
	end

	// Working variables and schedule window.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= h_q;
		end else if (ctl.busy) begin
			v_q <= v_n;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
		end
	end

	// Hash state: reloaded after a digest, accumulated after each block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) begin
				h_q[i] <= init_hash(3'(i));
			end
		end else if (hash_init) begin
			for (int i = 0; i < NumWords; i++) begin
				h_q[i] <= init_hash(3'(i));
			end
		end else if (ctl.done) begin
			h_q <= h_n;
		end
	end

	assign hash_word = h_q[hash_idx];

endmodule
`default_nettype wire

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
// Top level of the byte stream SHA-256 hasher with its sequencer.
//
// Channel  Dir  Payload                               Transfer when
// in_s     in   func, data_byte                       valid && ready
// out_s    out  digest_word, word_index, last_word    valid && ready
//
// Absorb is a single transfer; when it completes a block it goes on to one
// start, 64 rounds and one hash add, and word loads overlap the rounds.
// The rounds run as the 64-round loop of the shared round unit.
// Finish takes one such pass, or two when more than 55 bytes are held, then
// eight output transfers. Reset restores the initial hash and clears the
// counters. Output stalls hold the sequencer; input is not ready while busy.
`default_nettype none
module sha256_byte_stream_hasher_unit
	import sha_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	sha_stream_if.sink   in_s,
	sha_stream_if.source out_s
);

	state_t      state_q, state_d;
	logic [5:0]  fill_q;
	logic [28:0] done_q;
	logic [6:0]  cnt_q;
	logic        fin_q, second_q;
	logic [2:0]  widx_q;
	logic        in_fire, out_fire;
	logic        buf_we;
	logic [5:0]  buf_wa;
	logic [7:0]  buf_wd;
	logic [3:0]  rd_addr;
	logic [31:0] rd_word, msg_word, len_bits, hash_word;
	logic [5:0]  byte_pos;
	logic        hash_init;
	comp_ctl_t   ctl;

	assign in_fire  = in_s.valid && in_s.ready;
	assign out_fire = out_s.valid && out_s.ready;
	assign in_s.ready = (state_q == ST_IDLE);
	assign len_bits = {done_q, 3'b000};

	sha_block_buf u_buf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_addr (buf_wa),
		.wr_data (buf_wd),
		.rd_addr (rd_addr),
		.rd_word (rd_word)
	);

	sha_round_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.round     (cnt_q[5:0]),
		.msg_word  (msg_word),
		.hash_idx  (widx_q),
		.hash_init (hash_init),
		.hash_word (hash_word)
	);

	// Buffer writes come only from absorb transfers.
	assign buf_we = in_fire && (in_s.data.func == FuncAbsorb);
	assign buf_wa = fill_q;
	assign buf_wd = in_s.data.data_byte;
	// Rounds 0..15 read word cnt+1 ahead; word 0 is read during start.
	assign rd_addr = (state_q == ST_ROUND) ? 4'(cnt_q[3:0] + 4'd1) : 4'd0;

	// Padding mask on words read from the buffer for finish blocks.
	always_comb begin
		msg_word = rd_word;
		byte_pos = '0;
		if (fin_q) begin
			for (int b = 0; b < 4; b++) begin
				byte_pos = {cnt_q[3:0], 2'(b)};
				if (second_q || (byte_pos > fill_q)) begin
					msg_word[31-8*b -: 8] = 8'h00;
				end else if (byte_pos == fill_q) begin
					msg_word[31-8*b -: 8] = PadByte;
				end
			end
			if (cnt_q[3:0] == 4'd15 && (second_q || fill_q < 6'd56)) begin
				msg_word = len_bits;
			end
		end
	end

	// Next state and control.
	always_comb begin
		state_d = state_q;
		ctl = '0;
		hash_init = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (in_s.data.func == FuncFinish || fill_q == 6'd63)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.start = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.busy = 1'b1;
				if (cnt_q == 7'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				ctl.done = 1'b1;
				if (fin_q && !second_q && fill_q > 6'd55) begin
					state_d = ST_LOAD;
				end else if (fin_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_fire && widx_q == 3'd7) begin
					hash_init = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters and message bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			done_q   <= '0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			widx_q   <= '0;
		end else begin
			if (in_fire) begin
				fin_q    <= in_s.data.func;
				second_q <= 1'b0;
				if (in_s.data.func == FuncAbsorb) begin
					fill_q <= 6'(fill_q + 6'd1);
					done_q <= 29'(done_q + 29'd1);
				end
			end
			if (ctl.start) begin
				cnt_q <= '0;
			end else if (ctl.busy) begin
				cnt_q <= 7'(cnt_q + 7'd1);
			end
			if (ctl.done && fin_q) begin
				second_q <= 1'b1;
			end
			if (state_q == ST_EMIT && out_fire) begin
				widx_q <= 3'(widx_q + 3'd1);
				if (widx_q == 3'd7) begin
					fill_q <= '0;
					done_q <= '0;
				end
			end
		end
	end

	assign out_s.valid = (state_q == ST_EMIT);
	assign out_s.data.digest_word = hash_word;
	assign out_s.data.word_index  = widx_q;
	assign out_s.data.last_word   = (widx_q == 3'd7);

	// The input must never be ready while the round state is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> !in_s.ready)
		else $error("input ready during rounds");
	// A round pass always ends in the hash add.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && cnt_q == 7'd63) |=> (state_q == ST_ADD))
		else $error("round pass did not end in add");
	// After the last digest word the counters are cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && out_s.data.last_word) |=> (fill_q == 6'd0 && done_q == 29'd0))
		else $error("counters not cleared after digest");

endmodule
`default_nettype wire
